// File: sv/ptrqs_pkg.sv
package ptrqs_pkg;

    // fixed field widths
    localparam int CHAR_W      = 8;
    localparam int MEAN_SUM_W  = 48;
    localparam int COUNT_W     = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 208;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;

    // parameter defaults
    localparam int DEF_LANES        = 4;
    localparam int DEF_SURFACES     = 2;
    localparam int DEF_SWATHS       = 6;
    localparam int DEF_TILES        = 78;
    localparam int DEF_MAX_READ_LEN = 65535;
    localparam int DEF_FRAC_BITS    = 8;

    // configuration register reset values
    localparam logic [CHAR_W-1:0] QUAL_OFFSET_RST   = 8'd33;
    localparam logic [CHAR_W-1:0] Q_LOW_THR_RST     = 8'd20;
    localparam logic [CHAR_W-1:0] Q_HIGH_THR_RST    = 8'd30;
    localparam logic [CHAR_W-1:0] PERFECT_CHAR_RST  = 8'd70;
    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST    = 8'd78;

    // configuration register indexes
    localparam logic [2:0] REG_QUAL_OFFSET  = 3'd0;
    localparam logic [2:0] REG_Q_LOW_THR    = 3'd1;
    localparam logic [2:0] REG_Q_HIGH_THR   = 3'd2;
    localparam logic [2:0] REG_PERFECT_CHAR = 3'd3;
    localparam logic [2:0] REG_EMPTY_CHAR   = 3'd4;

    // input operation codes
    localparam logic [1:0] OP_BASE  = 2'd0;
    localparam logic [1:0] OP_EMPTY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // one tile table entry, mean_sum in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]    high_q_count;
        logic [COUNT_W-1:0]    low_q_count;
        logic [COUNT_W-1:0]    empty_count;
        logic [COUNT_W-1:0]    perfect_count;
        logic [COUNT_W-1:0]    read_count;
        logic [MEAN_SUM_W-1:0] mean_sum;
    } entry_t;

    // update request toward the tile table
    typedef struct packed {
        logic upd;
        logic perfect;
        logic empty;
    } tbl_ctrl_t;

    // saturating increment of a table counter
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// File: sv/ptrqs_div.sv
module ptrqs_div
    import ptrqs_pkg::*;
#(
    parameter int DVD_W = 40,
    parameter int DVS_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;

    // one restoring step per cycle
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        if (rem_sh >= {1'b0, dvs_reg}) begin
            rem_next = rem_sub[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/ptrqs_tile_table.sv
module ptrqs_tile_table
    import ptrqs_pkg::*;
#(
    parameter int ENTRIES = 3744,
    parameter int IDX_W   = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IDX_W-1:0]      addr,
    input  tbl_ctrl_t             ctrl,
    input  logic [MEAN_SUM_W-1:0] mean,
    input  logic [MEAN_SUM_W-1:0] lo_thr,
    input  logic [MEAN_SUM_W-1:0] hi_thr,
    output entry_t                rd_entry,
    output entry_t                new_entry,
    output logic                  clear_busy
);

    entry_t           mem [ENTRIES];
    entry_t           rd_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             clr_busy_reg;
    logic [MEAN_SUM_W:0] ms_sum;
    logic             pass_lo;
    logic             pass_hi;

    // clearing sweep after reset, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(ENTRIES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // entry update, all counters saturate
    always_comb begin
        ms_sum  = {1'b0, rd_reg.mean_sum} + {1'b0, mean};
        pass_lo = (mean >= lo_thr);
        pass_hi = pass_lo && (mean >= hi_thr);
        new_entry.mean_sum      = ms_sum[MEAN_SUM_W] ? {MEAN_SUM_W{1'b1}}
                                                     : ms_sum[MEAN_SUM_W-1:0];
        new_entry.read_count    = sat_inc(rd_reg.read_count);
        new_entry.perfect_count = ctrl.perfect ? sat_inc(rd_reg.perfect_count)
                                               : rd_reg.perfect_count;
        new_entry.empty_count   = ctrl.empty ? sat_inc(rd_reg.empty_count)
                                             : rd_reg.empty_count;
        new_entry.low_q_count   = pass_lo ? sat_inc(rd_reg.low_q_count)
                                          : rd_reg.low_q_count;
        new_entry.high_q_count  = pass_hi ? sat_inc(rd_reg.high_q_count)
                                          : rd_reg.high_q_count;
    end

    // single-port table memory with registered read
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctrl.upd) begin
            mem[addr] <= new_entry;
        end
        rd_reg <= mem[addr];
    end

    assign rd_entry   = rd_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// File: sv/per_tile_read_quality_stats.sv
// operation: a base transaction updates the running read statistics; a read close waits
// for the mean divider, which produces one quotient bit per cycle, before the table update
// throughput: bases one per cycle while s_tready is high; after a close or a table read s_tready
// stays low until the result is in the output register
// reset: synchronous active-low aresetn; a clearing pass over all LANES*SURFACES*SWATHS*TILES
// entries (3744 at defaults) zeroes the tile table, s_tready low meanwhile
module per_tile_read_quality_stats
    import ptrqs_pkg::*;
#(
    parameter int LANES        = DEF_LANES,
    parameter int SURFACES     = DEF_SURFACES,
    parameter int SWATHS       = DEF_SWATHS,
    parameter int TILES        = DEF_TILES,
    parameter int MAX_READ_LEN = DEF_MAX_READ_LEN,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // base_char[7:0], qual_char[15:8], lane[19:16], surface[21:20], swath[24:22],
    // tile[31:25]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // op[1:0]
    input  logic [1:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mean_sum[47:0], read_count[79:48], perfect_count[111:80], empty_count[143:112],
    // low_q_count[175:144], high_q_count[207:176]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic                  m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ENTRIES = LANES * SURFACES * SWATHS * TILES;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN + 1) : 1;
    localparam int SUM_W   = CNT_W + CHAR_W;
    localparam int DVD_W   = SUM_W + FRAC_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_RDOUT  = 3'd5;

    logic [2:0]        state_reg, state_next;

    logic [CHAR_W-1:0] qual_offset_reg, q_low_thr_reg, q_high_thr_reg;
    logic [CHAR_W-1:0] perfect_char_reg, empty_char_reg;

    logic [SUM_W-1:0]  run_sum_reg, sum_upd;
    logic [CNT_W-1:0]  run_cnt_reg, cnt_upd;
    logic              all_perf_reg, perf_upd;
    logic              all_empty_reg, empty_upd;

    logic [IDX_W-1:0]  addr_reg;
    logic              oor_reg;
    logic              zero_cnt_reg;
    logic              cl_perf_reg, cl_empty_reg;

    logic              m_tvalid_reg;
    entry_t            m_data_reg;
    logic              m_user_reg;

    logic [CHAR_W-1:0] in_base, in_qual;
    logic [3:0]        in_lane;
    logic [1:0]        in_surf;
    logic [2:0]        in_swath;
    logic [6:0]        in_tile;
    logic              in_range;
    logic [IDX_W-1:0]  in_idx;

    logic              accept;
    logic              is_close;
    logic              is_rd;
    logic              out_free;
    logic              cfg_wr;

    logic              div_done;
    logic [DVD_W-1:0]  div_quo;
    logic [DVD_W-1:0]  div_dvd;

    logic [MEAN_SUM_W-1:0] mean;
    logic [MEAN_SUM_W-1:0] lo_thr, hi_thr;
    logic [CHAR_W:0]       lo_base, hi_base;

    tbl_ctrl_t         tbl_ctrl;
    entry_t            rd_entry, new_entry;
    logic              clear_busy;

    // input field unpacking
    assign in_base  = s_tdata[7:0];
    assign in_qual  = s_tdata[15:8];
    assign in_lane  = s_tdata[19:16];
    assign in_surf  = s_tdata[21:20];
    assign in_swath = s_tdata[24:22];
    assign in_tile  = s_tdata[31:25];

    // coordinate check and flat table index
    always_comb begin
        in_range = ({1'b0, in_lane} < 5'(LANES)) && ({1'b0, in_surf} < 3'(SURFACES))
                && ({1'b0, in_swath} < 4'(SWATHS)) && ({1'b0, in_tile} < 8'(TILES));
        in_idx = IDX_W'(((IDX_W'(in_lane) * IDX_W'(SURFACES) + IDX_W'(in_surf))
                 * IDX_W'(SWATHS) + IDX_W'(in_swath)) * IDX_W'(TILES) + IDX_W'(in_tile));
        if (!in_range) begin
            in_idx = '0;
        end
    end

    // handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // operation decode
    always_comb begin
        is_close = 1'b0;
        is_rd    = 1'b0;
        case (s_tuser)
            OP_BASE:  is_close = s_tlast;
            OP_EMPTY: is_close = 1'b1;
            OP_READ:  is_rd    = 1'b1;
            default:  ;
        endcase
    end

    // running read statistics after this base
    always_comb begin
        sum_upd   = run_sum_reg;
        cnt_upd   = run_cnt_reg;
        perf_upd  = all_perf_reg;
        empty_upd = all_empty_reg;
        if (s_tuser == OP_BASE) begin
            if (run_cnt_reg < CNT_W'(MAX_READ_LEN)) begin
                sum_upd = run_sum_reg + SUM_W'(in_qual);
                cnt_upd = run_cnt_reg + CNT_W'(1);
            end
            if (in_qual != perfect_char_reg) begin
                perf_upd = 1'b0;
            end
            if (in_base != empty_char_reg) begin
                empty_upd = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg   <= '0;
            run_cnt_reg   <= '0;
            all_perf_reg  <= 1'b1;
            all_empty_reg <= 1'b1;
        end else if (accept && is_close) begin
            run_sum_reg   <= '0;
            run_cnt_reg   <= '0;
            all_perf_reg  <= 1'b1;
            all_empty_reg <= 1'b1;
        end else if (accept && (s_tuser == OP_BASE)) begin
            run_sum_reg   <= sum_upd;
            run_cnt_reg   <= cnt_upd;
            all_perf_reg  <= perf_upd;
            all_empty_reg <= empty_upd;
        end
    end

    // capture of the closing read or the read request
    always_ff @(posedge aclk) begin
        if (accept && (is_close || is_rd)) begin
            addr_reg     <= in_idx;
            oor_reg      <= !in_range;
            zero_cnt_reg <= (cnt_upd == '0);
            cl_perf_reg  <= perf_upd;
            cl_empty_reg <= empty_upd;
        end
    end

    // mean divider
    assign div_dvd = DVD_W'(sum_upd) << FRAC_BITS;

    ptrqs_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && is_close),
        .dividend (div_dvd),
        .divisor  (cnt_upd),
        .done     (div_done),
        .quotient (div_quo)
    );

    // mean and thresholds in fixed point
    always_comb begin
        mean    = zero_cnt_reg ? '0 : MEAN_SUM_W'(div_quo);
        lo_base = {1'b0, q_low_thr_reg} + {1'b0, qual_offset_reg};
        hi_base = {1'b0, q_high_thr_reg} + {1'b0, qual_offset_reg};
        lo_thr  = MEAN_SUM_W'(lo_base) << FRAC_BITS;
        hi_thr  = MEAN_SUM_W'(hi_base) << FRAC_BITS;
    end

    // table update request
    always_comb begin
        tbl_ctrl.upd     = (state_reg == ST_UPD) && out_free && !oor_reg;
        tbl_ctrl.perfect = cl_perf_reg;
        tbl_ctrl.empty   = cl_empty_reg;
    end

    ptrqs_tile_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .addr       (addr_reg),
        .ctrl       (tbl_ctrl),
        .mean       (mean),
        .lo_thr     (lo_thr),
        .hi_thr     (hi_thr),
        .rd_entry   (rd_entry),
        .new_entry  (new_entry),
        .clear_busy (clear_busy)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (!clear_busy) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept && is_close) begin
                    state_next = ST_DIV;
                end else if (accept && is_rd) begin
                    state_next = ST_RDWAIT;
                end
            end
            ST_DIV:    if (div_done) state_next = ST_UPD;
            ST_UPD:    if (out_free) state_next = ST_IDLE;
            ST_RDWAIT: state_next = ST_RDOUT;
            ST_RDOUT:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free && ((state_reg == ST_UPD) || (state_reg == ST_RDOUT))) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && ((state_reg == ST_UPD) || (state_reg == ST_RDOUT))) begin
            m_user_reg <= oor_reg;
            if (oor_reg) begin
                m_data_reg <= '0;
            end else if (state_reg == ST_UPD) begin
                m_data_reg <= new_entry;
            end else begin
                m_data_reg <= rd_entry;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qual_offset_reg  <= QUAL_OFFSET_RST;
            q_low_thr_reg    <= Q_LOW_THR_RST;
            q_high_thr_reg   <= Q_HIGH_THR_RST;
            perfect_char_reg <= PERFECT_CHAR_RST;
            empty_char_reg   <= EMPTY_CHAR_RST;
        end else if (cfg_wr && (paddr[1:0] == 2'b00)) begin
            unique case (paddr[4:2])
                REG_QUAL_OFFSET:  qual_offset_reg  <= pwdata[CHAR_W-1:0];
                REG_Q_LOW_THR:    q_low_thr_reg    <= pwdata[CHAR_W-1:0];
                REG_Q_HIGH_THR:   q_high_thr_reg   <= pwdata[CHAR_W-1:0];
                REG_PERFECT_CHAR: perfect_char_reg <= pwdata[CHAR_W-1:0];
                REG_EMPTY_CHAR:   empty_char_reg   <= pwdata[CHAR_W-1:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_QUAL_OFFSET:  prdata = APB_DATA_W'(qual_offset_reg);
            REG_Q_LOW_THR:    prdata = APB_DATA_W'(q_low_thr_reg);
            REG_Q_HIGH_THR:   prdata = APB_DATA_W'(q_high_thr_reg);
            REG_PERFECT_CHAR: prdata = APB_DATA_W'(perfect_char_reg);
            REG_EMPTY_CHAR:   prdata = APB_DATA_W'(empty_char_reg);
            default:          prdata = '0;
        endcase
    end

endmodule
